[design/iou_box_tracker_macros.svh]
// Assertion helpers for the box tracker.
`ifndef IOU_BOX_TRACKER_MACROS_SVH
`define IOU_BOX_TRACKER_MACROS_SVH

// Same-cycle implication, gated by reset.
`define IOU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated by reset.
`define IOU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/iou_pkg.sv]
package iou_pkg;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MATCH_NUM = 2'd0;
  localparam logic [1:0] REG_MATCH_DEN = 2'd1;
  localparam logic [1:0] REG_MAX_LOST  = 2'd2;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [7:0]  RST_MATCH_NUM = 8'd3;
  localparam logic [7:0]  RST_MATCH_DEN = 8'd10;
  localparam logic [7:0]  RST_MAX_LOST  = 8'd15;

  localparam logic [7:0]  LOST_SAT = 8'hFF;
  localparam logic [15:0] AGE_SAT  = 16'hFFFF;

  // sequencer codes
  localparam int unsigned ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
  localparam logic [ST_W-1:0] ST_AGE  = 4'd1;
  localparam logic [ST_W-1:0] ST_PSEL = 4'd2;
  localparam logic [ST_W-1:0] ST_OVL  = 4'd3;
  localparam logic [ST_W-1:0] ST_M1   = 4'd4;
  localparam logic [ST_W-1:0] ST_M2   = 4'd5;
  localparam logic [ST_W-1:0] ST_M3   = 4'd6;
  localparam logic [ST_W-1:0] ST_M4   = 4'd7;
  localparam logic [ST_W-1:0] ST_M5   = 4'd8;
  localparam logic [ST_W-1:0] ST_CMP  = 4'd9;
  localparam logic [ST_W-1:0] ST_TEND = 4'd10;
  localparam logic [ST_W-1:0] ST_NEW  = 4'd11;
  localparam logic [ST_W-1:0] ST_COMP = 4'd12;
  localparam logic [ST_W-1:0] ST_OUT  = 4'd13;

endpackage

[design/iou_in_if.sv]
interface iou_in_if #(parameter int CB = 12);
  logic          valid;
  logic          ready;
  logic          box_valid;
  logic [CB-1:0] box_x;
  logic [CB-1:0] box_y;
  logic [CB:0]   box_w;
  logic [CB:0]   box_h;
  logic          frame_end;

  modport source (output valid, box_valid, box_x, box_y, box_w, box_h, frame_end,
                  input ready);
  modport sink   (input valid, box_valid, box_x, box_y, box_w, box_h, frame_end,
                  output ready);
endinterface

[design/iou_out_if.sv]
interface iou_out_if #(parameter int CB = 12);
  logic          valid;
  logic          ready;
  logic          track_present;
  logic [15:0]   track_number;
  logic [CB-1:0] out_x;
  logic [CB-1:0] out_y;
  logic [CB:0]   out_w;
  logic [CB:0]   out_h;
  logic [7:0]    frames_lost;
  logic [15:0]   track_age;
  logic          is_new;
  logic          last_result;

  modport source (output valid, track_present, track_number, out_x, out_y, out_w, out_h,
                  frames_lost, track_age, is_new, last_result, input ready);
  modport sink   (input valid, track_present, track_number, out_x, out_y, out_w, out_h,
                  frames_lost, track_age, is_new, last_result, output ready);
endinterface

[design/iou_box_tracker.sv]
// Greedy IoU box tracker. Detection requests are buffered (up to MAX_DETS a
// frame, extras dropped) at one per cycle. A request with frame_end set starts
// frame processing, during which in_if.ready is low: an ageing step, then
// for every track T and every detection D a pair step through one shared
// multiplier (overlap, intersection, two areas, two cross-products, compare;
// the multiply steps only for an overlapping pair not yet taken), per track
// a select, end of scan and update step around its search, a pass over the
// buffered detections to open new tracks, a pass over the tracks to compact
// the table, then one result per track (or a single empty result) at the
// pace out_if.ready allows. IoU is compared exactly as inter*den > num*union.
// No clearing pass follows reset.
`include "iou_box_tracker_macros.svh"
module iou_box_tracker #(
  parameter int MAX_DETS   = 16,
  parameter int MAX_TRACKS = 16,
  parameter int COORD_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  iou_in_if.sink                           in_if,
  iou_out_if.source                        out_if,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [iou_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [iou_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [iou_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import iou_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int SB = CB + 1;        // size
  localparam int EB = CB + 2;        // far edge
  localparam int AB = 2 * SB;        // area
  localparam int UB = AB + 1;        // union
  localparam int PB = 2 * UB;        // cross-product
  localparam int DI = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
  localparam int DC = $clog2(MAX_DETS + 1);
  localparam int TI = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int TC = $clog2(MAX_TRACKS + 1);

  // config registers
  logic [7:0] match_num_r, match_den_r, max_lost_r;

  // detection buffer
  logic [CB-1:0] det_x_r [MAX_DETS];
  logic [CB-1:0] det_y_r [MAX_DETS];
  logic [SB-1:0] det_w_r [MAX_DETS];
  logic [SB-1:0] det_h_r [MAX_DETS];
  logic [DC-1:0] det_cnt_r;
  logic [MAX_DETS-1:0] taken_r;

  // track table; used slots are the prefix [0, n_r)
  logic [15:0]   sl_id_r   [MAX_TRACKS];
  logic [CB-1:0] sl_x_r    [MAX_TRACKS];
  logic [CB-1:0] sl_y_r    [MAX_TRACKS];
  logic [SB-1:0] sl_w_r    [MAX_TRACKS];
  logic [SB-1:0] sl_h_r    [MAX_TRACKS];
  logic [7:0]    sl_lost_r [MAX_TRACKS];
  logic [15:0]   sl_age_r  [MAX_TRACKS];
  logic [MAX_TRACKS-1:0] fresh_r;
  logic [TC-1:0] n_r;
  logic [15:0]   next_id_r;

  // sequencer
  logic [ST_W-1:0] state_r, state_nxt;
  logic [TC-1:0] i_r, k_r;
  logic [DC-1:0] d_r;
  // index of the best detection so far
  logic [DI-1:0] bdi_r;

  // pair datapath
  logic [SB-1:0] iw_r, ih_r;
  logic [AB-1:0] inter_r, at_r, ad_r;
  logic [UB-1:0] un_r;
  logic [PB-1:0] lhs_r, rhs_r;
  logic [AB-1:0] bi_r;
  logic [UB-1:0] bu_r;
  logic          best_vld_r;
  logic [CB-1:0] bx_r, by_r;
  logic [SB-1:0] bw_r, bh_r;

  // output register
  logic          o_vld_r, o_pres_r, o_new_r, o_last_r;
  logic [15:0]   o_id_r, o_age_r;
  logic [CB-1:0] o_x_r, o_y_r;
  logic [SB-1:0] o_w_r, o_h_r;
  logic [7:0]    o_lost_r;

  logic in_acc, cfg_wr, out_free;
  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready  = 1'b1;
  assign out_free    = !o_vld_r || out_if.ready;

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[3:2])
      REG_MATCH_NUM: cfg_prdata[7:0] = match_num_r;
      REG_MATCH_DEN: cfg_prdata[7:0] = match_den_r;
      REG_MAX_LOST:  cfg_prdata[7:0] = max_lost_r;
      default:       cfg_prdata = '0;
    endcase
  end

  // current track (i_r) and detection (d_r) views
  logic [TI-1:0] ti;
  logic [DI-1:0] di;
  assign ti = i_r[TI-1:0];
  assign di = d_r[DI-1:0];

  logic [CB-1:0] tx, ty, dx, dy;
  logic [SB-1:0] tw, th, dw, dh;
  assign tx = sl_x_r[ti];
  assign ty = sl_y_r[ti];
  assign tw = sl_w_r[ti];
  assign th = sl_h_r[ti];
  assign dx = det_x_r[di];
  assign dy = det_y_r[di];
  assign dw = det_w_r[di];
  assign dh = det_h_r[di];

  // overlap geometry
  logic [EB-1:0] x1, y1, x2, y2, tx2, dx2, ty2, dy2, ew, eh;
  logic          ovl;
  always_comb begin
    x1  = (tx > dx) ? EB'(tx) : EB'(dx);
    y1  = (ty > dy) ? EB'(ty) : EB'(dy);
    tx2 = EB'(tx) + EB'(tw);
    dx2 = EB'(dx) + EB'(dw);
    ty2 = EB'(ty) + EB'(th);
    dy2 = EB'(dy) + EB'(dh);
    x2  = (tx2 < dx2) ? tx2 : dx2;
    y2  = (ty2 < dy2) ? ty2 : dy2;
    ovl = (x2 > x1) && (y2 > y1);
    ew  = x2 - x1;
    eh  = y2 - y1;
  end

  // the shared multiplier
  logic [UB-1:0] mul_a, mul_b;
  logic [PB-1:0] mul_p;
  always_comb begin
    case (state_r)
      ST_M1:   begin mul_a = UB'(iw_r);    mul_b = UB'(ih_r); end
      ST_M2:   begin mul_a = UB'(tw);      mul_b = UB'(th);   end
      ST_M3:   begin mul_a = UB'(dw);      mul_b = UB'(dh);   end
      ST_M4:   begin mul_a = UB'(inter_r); mul_b = bu_r;      end
      ST_M5:   begin mul_a = UB'(bi_r);    mul_b = un_r;      end
      default: begin mul_a = '0;           mul_b = '0;        end
    endcase
    mul_p = mul_a * mul_b;
  end

  logic det_full, tbl_full, last_trk;
  assign det_full = (det_cnt_r == DC'(MAX_DETS));
  assign tbl_full = (n_r == TC'(MAX_TRACKS));
  assign last_trk = (i_r + TC'(1) == n_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && in_if.frame_end) state_nxt = ST_AGE;
      ST_AGE:  state_nxt = (n_r == '0) ? ST_NEW : ST_PSEL;
      ST_PSEL: state_nxt = ST_OVL;
      ST_OVL: begin
        if (d_r == det_cnt_r) state_nxt = ST_TEND;
        else if (!taken_r[di] && ovl) state_nxt = ST_M1;
      end
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = ST_M3;
      ST_M3:   state_nxt = ST_M4;
      ST_M4:   state_nxt = ST_M5;
      ST_M5:   state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_OVL;
      ST_TEND: state_nxt = last_trk ? ST_NEW : ST_PSEL;
      ST_NEW:  if (d_r == det_cnt_r) state_nxt = ST_COMP;
      ST_COMP: if (i_r == n_r) state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free && (n_r == '0 || last_trk)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      match_num_r <= RST_MATCH_NUM;
      match_den_r <= RST_MATCH_DEN;
      max_lost_r  <= RST_MAX_LOST;
      det_cnt_r   <= '0;
      taken_r     <= '0;
      n_r         <= '0;
      next_id_r   <= '0;
      fresh_r     <= '0;
      o_vld_r     <= 1'b0;
      i_r         <= '0;
      k_r         <= '0;
      d_r         <= '0;
      best_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          REG_MATCH_NUM: match_num_r <= cfg_pwdata[7:0];
          REG_MATCH_DEN: match_den_r <= cfg_pwdata[7:0];
          REG_MAX_LOST:  max_lost_r  <= cfg_pwdata[7:0];
          default: ;
        endcase
      end
      // result register: load a new result or drop the one taken
      if (state_r == ST_OUT && out_free) o_vld_r <= 1'b1;
      else if (out_if.ready) o_vld_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && in_if.box_valid && !det_full) det_cnt_r <= det_cnt_r + DC'(1);
          i_r <= '0;
        end
        ST_AGE: begin
          taken_r <= '0;
          fresh_r <= '0;
          d_r     <= '0;
        end
        ST_PSEL: begin
          d_r        <= '0;
          best_vld_r <= 1'b0;
        end
        ST_OVL: begin
          if (d_r != det_cnt_r && (taken_r[di] || !ovl)) d_r <= d_r + DC'(1);
        end
        ST_CMP: begin
          if (lhs_r > rhs_r) best_vld_r <= 1'b1;
          d_r <= d_r + DC'(1);
        end
        ST_TEND: begin
          i_r <= i_r + TC'(1);
          d_r <= '0;
        end
        ST_NEW: begin
          if (d_r != det_cnt_r) begin
            d_r <= d_r + DC'(1);
            if (!taken_r[di] && !tbl_full) begin
              n_r       <= n_r + TC'(1);
              next_id_r <= next_id_r + 16'd1;
              fresh_r[n_r[TI-1:0]] <= 1'b1;
            end
          end else begin
            i_r <= '0;
            k_r <= '0;
          end
        end
        ST_COMP: begin
          if (i_r == n_r) begin
            n_r       <= k_r;
            i_r       <= '0;
            det_cnt_r <= '0;
            taken_r   <= '0;
          end else begin
            i_r <= i_r + TC'(1);
            if (sl_lost_r[ti] <= max_lost_r) begin
              k_r <= k_r + TC'(1);
              fresh_r[k_r[TI-1:0]] <= fresh_r[ti];
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            i_r <= i_r + TC'(1);
          end
        end
        default: ;
      endcase
      if (state_r == ST_TEND && best_vld_r) taken_r[bdi_r] <= 1'b1;
    end
  end

  // payload and storage
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc && in_if.box_valid && !det_full) begin
      det_x_r[det_cnt_r[DI-1:0]] <= in_if.box_x;
      det_y_r[det_cnt_r[DI-1:0]] <= in_if.box_y;
      det_w_r[det_cnt_r[DI-1:0]] <= in_if.box_w;
      det_h_r[det_cnt_r[DI-1:0]] <= in_if.box_h;
    end
    unique case (state_r)
      ST_AGE: begin
        for (int j = 0; j < MAX_TRACKS; j++) begin
          if (TC'(j) < n_r && sl_lost_r[j] != LOST_SAT) sl_lost_r[j] <= sl_lost_r[j] + 8'd1;
        end
      end
      ST_PSEL: begin
        bi_r <= AB'(match_num_r);
        bu_r <= UB'(match_den_r);
      end
      ST_OVL: begin
        iw_r <= ew[SB-1:0];
        ih_r <= eh[SB-1:0];
      end
      ST_M1: inter_r <= mul_p[AB-1:0];
      ST_M2: at_r    <= mul_p[AB-1:0];
      ST_M3: ad_r    <= mul_p[AB-1:0];
      ST_M4: begin
        un_r  <= UB'(at_r) + UB'(ad_r) - UB'(inter_r);
        lhs_r <= mul_p;
      end
      ST_M5: rhs_r <= mul_p;
      ST_CMP: begin
        if (lhs_r > rhs_r) begin
          bi_r  <= inter_r;
          bu_r  <= un_r;
          bdi_r <= di;
          bx_r  <= dx;
          by_r  <= dy;
          bw_r  <= dw;
          bh_r  <= dh;
        end
      end
      ST_TEND: begin
        if (best_vld_r) begin
          sl_x_r[ti]    <= bx_r;
          sl_y_r[ti]    <= by_r;
          sl_w_r[ti]    <= bw_r;
          sl_h_r[ti]    <= bh_r;
          sl_lost_r[ti] <= 8'd0;
          if (sl_age_r[ti] != AGE_SAT) sl_age_r[ti] <= sl_age_r[ti] + 16'd1;
        end
      end
      ST_NEW: begin
        if (d_r != det_cnt_r && !taken_r[di] && !tbl_full) begin
          sl_id_r[n_r[TI-1:0]]   <= next_id_r;
          sl_x_r[n_r[TI-1:0]]    <= dx;
          sl_y_r[n_r[TI-1:0]]    <= dy;
          sl_w_r[n_r[TI-1:0]]    <= dw;
          sl_h_r[n_r[TI-1:0]]    <= dh;
          sl_lost_r[n_r[TI-1:0]] <= 8'd0;
          sl_age_r[n_r[TI-1:0]]  <= 16'd0;
        end
      end
      ST_COMP: begin
        if (i_r != n_r && sl_lost_r[ti] <= max_lost_r) begin
          sl_id_r[k_r[TI-1:0]]   <= sl_id_r[ti];
          sl_x_r[k_r[TI-1:0]]    <= tx;
          sl_y_r[k_r[TI-1:0]]    <= ty;
          sl_w_r[k_r[TI-1:0]]    <= tw;
          sl_h_r[k_r[TI-1:0]]    <= th;
          sl_lost_r[k_r[TI-1:0]] <= sl_lost_r[ti];
          sl_age_r[k_r[TI-1:0]]  <= sl_age_r[ti];
        end
      end
      ST_OUT: begin
        if (out_free) begin
          if (n_r == '0) begin
            // empty table: one blank result closes the frame
            o_pres_r <= 1'b0;
            o_id_r   <= '0;
            o_x_r    <= '0;
            o_y_r    <= '0;
            o_w_r    <= '0;
            o_h_r    <= '0;
            o_lost_r <= '0;
            o_age_r  <= '0;
            o_new_r  <= 1'b0;
            o_last_r <= 1'b1;
          end else begin
            o_pres_r <= 1'b1;
            o_id_r   <= sl_id_r[ti];
            o_x_r    <= tx;
            o_y_r    <= ty;
            o_w_r    <= tw;
            o_h_r    <= th;
            o_lost_r <= sl_lost_r[ti];
            o_age_r  <= sl_age_r[ti];
            o_new_r  <= fresh_r[ti];
            o_last_r <= last_trk;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_if.valid         = o_vld_r;
  assign out_if.track_present = o_pres_r;
  assign out_if.track_number  = o_id_r;
  assign out_if.out_x         = o_x_r;
  assign out_if.out_y         = o_y_r;
  assign out_if.out_w         = o_w_r;
  assign out_if.out_h         = o_h_r;
  assign out_if.frames_lost   = o_lost_r;
  assign out_if.track_age     = o_age_r;
  assign out_if.is_new        = o_new_r;
  assign out_if.last_result   = o_last_r;

  `IOU_ASSERT_IMP(a_det_bound, 1'b1, det_cnt_r <= DC'(MAX_DETS), "detection count overflow")
  `IOU_ASSERT_IMP(a_trk_bound, 1'b1, n_r <= TC'(MAX_TRACKS), "track count overflow")
  `IOU_ASSERT_IMP(a_blank_last, o_vld_r && !o_pres_r, o_last_r, "blank result not last")
  `IOU_ASSERT_IMP(a_start, state_r == ST_IDLE && state_nxt != ST_IDLE,
                  in_acc && in_if.frame_end, "frame started without frame end")
  `IOU_ASSERT_NXT(a_flush, state_r == ST_COMP && i_r == n_r, det_cnt_r == '0,
                  "detection buffer not flushed")

endmodule

[bench/iou_box_tracker_test.sv]
`timescale 1ns / 100ps

// Box tracker bench: frames of detection requests are queued by the scenario
// block and fed by a clocked driver; a clocked predictor follows every accepted
// request and queues the track reports it expects; a clocked monitor checks
// each report leaving the block against the oldest expected one.
module iou_box_tracker_test;
  import iou_pkg::*;

  localparam int NDET = 16;
  localparam int NTRK = 16;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int RANDOM_REQUESTS = 230;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] w;
    logic [12:0] h;
  } box_t;

  typedef struct packed {
    logic  box_valid;
    box_t  box;
    logic  frame_end;
  } det_req_t;

  typedef struct packed {
    logic        track_present;
    logic [15:0] track_number;
    box_t        box;
    logic [7:0]  frames_lost;
    logic [15:0] track_age;
    logic        is_new;
    logic        last_result;
  } track_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  iou_in_if  #(.CB(12)) det_ch ();
  iou_out_if #(.CB(12)) trk_ch ();

  iou_box_tracker dut (
    .clk(clk), .rst_n(rst_n), .in_if(det_ch.sink), .out_if(trk_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // known values on every input from time zero
  initial begin
    det_ch.valid = 1'b0;
    det_ch.box_valid = 1'b0;
    det_ch.box_x = '0;
    det_ch.box_y = '0;
    det_ch.box_w = '0;
    det_ch.box_h = '0;
    det_ch.frame_end = 1'b0;
    trk_ch.ready = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the registers, detection buffer and track table
  // ---------------------------------------------------------------------------
  logic [7:0]  thr_num = RST_MATCH_NUM;
  logic [7:0]  thr_den = RST_MATCH_DEN;
  logic [7:0]  lost_limit = RST_MAX_LOST;
  box_t        frame_dets [NDET];
  int          frame_det_n = 0;
  int          track_n = 0;
  logic [15:0] trk_ident [NTRK];
  box_t        trk_box [NTRK];
  logic [7:0]  trk_lost [NTRK];
  logic [15:0] trk_age [NTRK];
  logic [15:0] ident_next = '0;

  track_report_t track_reports_q [$];
  det_req_t      pending_reqs [$];

  int mismatches = 0;
  int reports_seen = 0;
  int frames_done = 0;
  int matches_seen = 0;
  int cycles = 0;
  bit quiet = 1'b0;          // no idling on either side
  int hold_reqs = 0;         // scenario asks for a long receiver hold-off
  int hold_done = 0;

  // exact intersection and union areas; 0 when the boxes do not overlap
  function automatic bit box_overlap(input box_t a, input box_t b,
                                     output longint unsigned inter,
                                     output longint unsigned uni);
    longint unsigned x1, y1, x2, y2, ax2, bx2, ay2, by2;
    x1 = 64'((a.x > b.x) ? a.x : b.x);
    y1 = 64'((a.y > b.y) ? a.y : b.y);
    ax2 = longint'(a.x) + a.w;
    bx2 = longint'(b.x) + b.w;
    ay2 = longint'(a.y) + a.h;
    by2 = longint'(b.y) + b.h;
    x2 = (ax2 < bx2) ? ax2 : bx2;
    y2 = (ay2 < by2) ? ay2 : by2;
    inter = 0;
    uni = 0;
    if (x2 <= x1 || y2 <= y1) return 1'b0;
    inter = (x2 - x1) * (y2 - y1);
    uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
    return 1'b1;
  endfunction

  // buffers the box; on frame end ages, matches greedily, opens, prunes, reports
  task automatic track_frame(input det_req_t req);
    logic            fresh [NTRK];
    logic [NDET-1:0] taken;
    longint unsigned best_i, best_u, it, un;
    int              best, k;
    track_report_t   rep;
    if (req.box_valid && frame_det_n < NDET) begin
      frame_dets[frame_det_n] = req.box;
      frame_det_n++;
    end
    if (!req.frame_end) return;
    taken = '0;
    for (int i = 0; i < NTRK; i++) fresh[i] = 1'b0;
    for (int i = 0; i < track_n; i++)
      if (trk_lost[i] != LOST_SAT) trk_lost[i]++;
    for (int i = 0; i < track_n; i++) begin
      best_i = 64'(thr_num);
      best_u = 64'(thr_den);
      best = -1;
      for (int d = 0; d < frame_det_n; d++) begin
        if (taken[d]) continue;
        if (!box_overlap(trk_box[i], frame_dets[d], it, un)) continue;
        if (it * best_u > best_i * un) begin
          best_i = it;
          best_u = un;
          best = d;
        end
      end
      if (best >= 0) begin
        taken[best] = 1'b1;
        trk_box[i] = frame_dets[best];
        trk_lost[i] = '0;
        if (trk_age[i] != AGE_SAT) trk_age[i]++;
        matches_seen++;
      end
    end
    for (int d = 0; d < frame_det_n; d++) begin
      if (taken[d] || track_n >= NTRK) continue;
      trk_ident[track_n] = ident_next;
      ident_next++;
      trk_box[track_n] = frame_dets[d];
      trk_lost[track_n] = '0;
      trk_age[track_n] = '0;
      fresh[track_n] = 1'b1;
      track_n++;
    end
    k = 0;
    for (int i = 0; i < track_n; i++) begin
      if (trk_lost[i] > lost_limit) continue;
      trk_ident[k] = trk_ident[i];
      trk_box[k] = trk_box[i];
      trk_lost[k] = trk_lost[i];
      trk_age[k] = trk_age[i];
      fresh[k] = fresh[i];
      k++;
    end
    track_n = k;
    frame_det_n = 0;
    frames_done++;
    if (track_n == 0) begin
      rep = '0;
      rep.last_result = 1'b1;
      track_reports_q = {track_reports_q, rep};
    end
    for (int r = 0; r < track_n; r++) begin
      rep.track_present = 1'b1;
      rep.track_number = trk_ident[r];
      rep.box = trk_box[r];
      rep.frames_lost = trk_lost[r];
      rep.track_age = trk_age[r];
      rep.is_new = fresh[r];
      rep.last_result = (r == track_n - 1);
      track_reports_q = {track_reports_q, rep};
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one request per handshake, random bursts of idle cycles
  // ---------------------------------------------------------------------------
  int drv_idle = 0;
  always @(posedge clk) begin
    det_req_t nxt;
    if (!rst_n) begin
      det_ch.valid <= 1'b0;
      drv_idle <= 0;
    end else if (!det_ch.valid || det_ch.ready) begin
      if (drv_idle != 0) begin
        drv_idle <= drv_idle - 1;
        det_ch.valid <= 1'b0;
      end else if (!quiet && pending_reqs.size() != 0 && $urandom_range(0, 6) == 0) begin
        drv_idle <= $urandom_range(0, 3);
        det_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        det_ch.valid <= 1'b1;
        det_ch.box_valid <= nxt.box_valid;
        det_ch.box_x <= nxt.box.x;
        det_ch.box_y <= nxt.box.y;
        det_ch.box_w <= nxt.box.w;
        det_ch.box_h <= nxt.box.h;
        det_ch.frame_end <= nxt.frame_end;
      end else begin
        det_ch.valid <= 1'b0;
      end
    end
  end

  // predictor follows every accepted request
  always @(posedge clk) begin
    det_req_t acc;
    if (rst_n && det_ch.valid && det_ch.ready) begin
      acc.box_valid = det_ch.box_valid;
      acc.box = {det_ch.box_x, det_ch.box_y, det_ch.box_w, det_ch.box_h};
      acc.frame_end = det_ch.frame_end;
      track_frame(acc);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when the scenario asks
  // ---------------------------------------------------------------------------
  int rcv_stall = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      trk_ch.ready <= 1'b0;
      rcv_stall <= 0;
    end else if (hold_done != hold_reqs) begin
      hold_done <= hold_reqs;
      rcv_stall <= 600;
      trk_ch.ready <= 1'b0;
    end else if (rcv_stall != 0) begin
      rcv_stall <= rcv_stall - 1;
      trk_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      rcv_stall <= $urandom_range(0, 3);
      trk_ch.ready <= 1'b0;
    end else begin
      trk_ch.ready <= 1'b1;
    end
  end

  // monitor: each report against the oldest expected one
  always @(posedge clk) begin
    track_report_t got, want;
    if (rst_n && trk_ch.valid && trk_ch.ready) begin
      got.track_present = trk_ch.track_present;
      got.track_number = trk_ch.track_number;
      got.box = {trk_ch.out_x, trk_ch.out_y, trk_ch.out_w, trk_ch.out_h};
      got.frames_lost = trk_ch.frames_lost;
      got.track_age = trk_ch.track_age;
      got.is_new = trk_ch.is_new;
      got.last_result = trk_ch.last_result;
      reports_seen++;
      if (track_reports_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report %p", got);
      end else begin
        want = track_reports_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("report mismatch\n  exp %p\n  got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Scenario
  // ---------------------------------------------------------------------------
  task automatic push_req(input logic bv, input int x, input int y, input int w,
                          input int h, input logic fe);
    det_req_t r;
    r.box_valid = bv;
    r.box.x = 12'(x);
    r.box.y = 12'(y);
    r.box.w = 13'(w);
    r.box.h = 13'(h);
    r.frame_end = fe;
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {16'($urandom_range(0, 65535)), 8'h00, val} & 32'hFFFF_00FF;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_MATCH_NUM: thr_num = val;
      REG_MATCH_DEN: thr_den = val;
      default:       lost_limit = val;
    endcase
  endtask

  task automatic set_thresholds(input logic [7:0] num, input logic [7:0] den,
                                input logic [7:0] lim);
    cfg_write(REG_MATCH_NUM, num);
    cfg_write(REG_MATCH_DEN, den);
    cfg_write(REG_MAX_LOST, lim);
  endtask

  // everything fed, every report back, then a pause for the block to settle
  task automatic drain();
    while (pending_reqs.size() != 0 || det_ch.valid || track_reports_q.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // moving objects give matches; noise boxes cover the full field range
  int obj_x [6], obj_y [6], obj_w [6], obj_h [6];
  int random_reqs = 0;

  task automatic random_frames(input int budget);
    int n;
    for (int o = 0; o < 6; o++) begin
      obj_x[o] = $urandom_range(0, 3500);
      obj_y[o] = $urandom_range(0, 3500);
      obj_w[o] = $urandom_range(8, 500);
      obj_h[o] = $urandom_range(8, 500);
    end
    n = 0;
    while (n < budget) begin
      for (int o = 0; o < 6; o++) begin
        obj_x[o] = (obj_x[o] + $urandom_range(0, 24) - 12) & 12'hFFF;
        obj_y[o] = (obj_y[o] + $urandom_range(0, 24) - 12) & 12'hFFF;
        if ($urandom_range(0, 4) != 0) begin
          push_req(1'b1, obj_x[o], obj_y[o], obj_w[o] + $urandom_range(0, 6),
                   obj_h[o] + $urandom_range(0, 6), 1'b0);
          n++;
        end
      end
      repeat ($urandom_range(0, 2)) begin
        push_req(1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(1, 4096), $urandom_range(1, 4096), 1'b0);
        n++;
      end
      // an ignored request now and then
      if ($urandom_range(0, 5) == 0)
        push_req(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(1, 4096), $urandom_range(1, 4096), 1'b0);
      // frame end, with or without a box of its own
      if ($urandom_range(0, 1) != 0) begin
        push_req(1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(1, 4096), $urandom_range(1, 4096), 1'b1);
        n++;
      end else begin
        push_req(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(1, 4096), $urandom_range(1, 4096), 1'b1);
      end
      n++;
    end
    random_reqs += n;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset thresholds: empty table, field extremes, box with frame end
    push_req(1'b0, 0, 0, 1, 1, 1'b1);
    push_req(1'b1, 0, 0, 1, 1, 1'b1);
    push_req(1'b1, 4095, 4095, 4096, 4096, 1'b1);
    push_req(1'b1, 1, 0, 1, 1, 1'b0);
    push_req(1'b1, 4000, 4000, 4000, 4096, 1'b1);
    // seventeen disjoint boxes: buffer overflows, table fills
    for (int i = 0; i < 17; i++)
      push_req(1'b1, (i % 8) * 500, (i / 8) * 1000 + 100, 100, 100, 1'b0);
    push_req(1'b0, 0, 0, 1, 1, 1'b1);
    // table full: a fresh disjoint detection is dropped
    push_req(1'b1, 3000, 3500, 50, 50, 1'b1);
    drain();

    // table emptied with the tightest lost limit, loosest match threshold
    set_thresholds(8'd1, 8'd255, 8'd0);
    push_req(1'b0, 0, 0, 1, 1, 1'b1);
    random_frames(RANDOM_REQUESTS / 5);
    drain();

    // threshold above any IoU: nothing ever matches, tracks linger
    set_thresholds(8'd255, 8'd1, 8'd254);
    random_frames(RANDOM_REQUESTS / 5);
    drain();

    // long receiver hold-off while the sender keeps offering frames
    set_thresholds(8'd1, 8'd2, 8'd3);
    hold_reqs = hold_reqs + 1;
    random_frames(RANDOM_REQUESTS / 5);
    drain();

    set_thresholds(8'd1, 8'd100, 8'd1);
    random_frames(RANDOM_REQUESTS / 5);
    drain();

    // final stretch at reset values without idling
    set_thresholds(RST_MATCH_NUM, RST_MATCH_DEN, RST_MAX_LOST);
    quiet = 1'b1;
    random_frames(RANDOM_REQUESTS / 5);
    drain();
    repeat (100) @(posedge clk);

    $display("covered %0d frames, %0d random requests, %0d track reports, %0d matches",
             frames_done, random_reqs, reports_seen, matches_seen);
    $display("six threshold settings incl. extremes; %0d mismatches", mismatches);
    if (mismatches == 0 && track_reports_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[iou_box_tracker.f]
+incdir+design
design/iou_pkg.sv
design/iou_in_if.sv
design/iou_out_if.sv
design/iou_box_tracker.sv
bench/iou_box_tracker_test.sv
